// ===== src/bfx_pkg.sv =====
// Shared types and constants for the instruction executor.
package bfx_pkg;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;
    localparam int SKIP_W = 16;
    localparam logic [SKIP_W-1:0] SKIP_MAX = 16'hFFFF;

    localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;
    localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;
    localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;
    localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;
    localparam logic [BYTE_W-1:0] OP_OUT   = 8'h2E;
    localparam logic [BYTE_W-1:0] OP_IN    = 8'h2C;
    localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_FULL      = 2'd2,
        ST_UNCLOSED  = 2'd3
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] opcode;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] in_byte;
        logic              program_end;
    } t_bfx_req;

    typedef struct packed {
        logic              out_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              jump_taken;
        logic [ADDR_W-1:0] jump_target;
        logic              skipping;
        t_status           status;
    } t_bfx_rsp;

endpackage

// ===== src/bf_instruction_executor.sv =====
// Top level of the instruction executor: tape, loop stack and execute step.
//
// A new request is not taken until the last has executed. The tape cell and
// the top of the loop stack are read from synchronous RAM on the edge that
// accepts a request; the execute cycle then modifies, writes them back and
// loads the result register, after which the next request is taken. A result
// waiting in the output register does not block acceptance; the execute
// cycle holds only if that register is still full when it would load. After
// reset the tape is zeroed by a sweep, one cell per cycle, during which no
// request is accepted.
module bf_instruction_executor
    import bfx_pkg::*;
#(
    parameter int TAPE_CELLS           = 32768,
    parameter int LOOP_DEPTH           = 64,
    parameter int PROGRAM_ADDRESS_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_bfx_req i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_bfx_rsp o_rsp
);

    localparam int PW  = $clog2(TAPE_CELLS);
    localparam int SAW = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam int CW  = $clog2(LOOP_DEPTH + 1);
    localparam int SW  = (PROGRAM_ADDRESS_BITS < ADDR_W) ? PROGRAM_ADDRESS_BITS : ADDR_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(TAPE_CELLS - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(LOOP_DEPTH);

    logic              r_clr;
    logic [PW-1:0]     r_clr_addr;
    logic              r_busy;
    t_bfx_req          r_req;
    logic [PW-1:0]     r_ptr;
    logic [CW-1:0]     r_cnt;
    logic [SKIP_W-1:0] r_skip;
    logic              r_out_valid;
    t_bfx_rsp          r_rsp;

    logic [PW-1:0]     n_ptr;
    logic [CW-1:0]     n_cnt;
    logic [SKIP_W-1:0] n_skip;
    t_bfx_rsp          n_rsp;
    logic [BYTE_W-1:0] n_cell;
    logic              n_tape_wr;
    logic              n_push;

    logic              acc;
    logic              cmt;
    logic              tape_we;
    logic [PW-1:0]     tape_waddr;
    logic [BYTE_W-1:0] tape_wdata;
    logic [BYTE_W-1:0] cur_cell;
    logic [CW-1:0]     cnt_m1;
    logic [SW-1:0]     stack_rdata;
    logic [SW-1:0]     push_addr;

    assign o_ready = !r_busy && !r_clr;
    assign acc     = i_valid && o_ready;
    assign cmt     = r_busy && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    assign tape_we    = r_clr || (cmt && n_tape_wr);
    assign tape_waddr = r_clr ? r_clr_addr : r_ptr;
    assign tape_wdata = r_clr ? '0 : n_cell;
    assign cnt_m1     = r_cnt - 1'b1;
    assign push_addr  = SW'(r_req.address[SW-1:0] + 1'b1);

    bfx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TAPE_CELLS)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_re    (acc),
        .i_raddr (r_ptr),
        .o_rdata (cur_cell)
    );

    bfx_ram #(
        .WIDTH (SW),
        .DEPTH (LOOP_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (cmt && n_push),
        .i_waddr (r_cnt[SAW-1:0]),
        .i_wdata (push_addr),
        .i_re    (acc),
        .i_raddr (cnt_m1[SAW-1:0]),
        .o_rdata (stack_rdata)
    );

    always_comb begin
        n_ptr     = r_ptr;
        n_cnt     = r_cnt;
        n_skip    = r_skip;
        n_cell    = cur_cell;
        n_tape_wr = 1'b0;
        n_push    = 1'b0;
        n_rsp     = '0;
        n_rsp.status = ST_OK;

        if (r_req.program_end) begin
            if (r_cnt != '0 || r_skip != '0) begin
                n_rsp.status = ST_UNCLOSED;
            end
            n_cnt  = '0;
            n_skip = '0;
        end else if (r_skip != '0) begin
            if (r_req.opcode == OP_OPEN) begin
                if (r_skip != SKIP_MAX) begin
                    n_skip = r_skip + 1'b1;
                end
            end else if (r_req.opcode == OP_CLOSE) begin
                n_skip = r_skip - 1'b1;
            end
        end else begin
            case (r_req.opcode)
                OP_INC: begin
                    n_cell    = cur_cell + 1'b1;
                    n_tape_wr = 1'b1;
                end
                OP_DEC: begin
                    n_cell    = cur_cell - 1'b1;
                    n_tape_wr = 1'b1;
                end
                OP_RIGHT: begin
                    n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                end
                OP_LEFT: begin
                    n_ptr = (r_ptr == '0) ? PTR_LAST : r_ptr - 1'b1;
                end
                OP_OUT: begin
                    n_rsp.out_valid = 1'b1;
                    n_rsp.out_byte  = cur_cell;
                end
                OP_IN: begin
                    n_cell    = r_req.in_byte;
                    n_tape_wr = 1'b1;
                end
                OP_OPEN: begin
                    if (cur_cell == '0) begin
                        n_skip = SKIP_W'(1);
                    end else if (r_cnt >= CNT_FULL) begin
                        n_rsp.status = ST_FULL;
                    end else begin
                        n_push = 1'b1;
                        n_cnt  = r_cnt + 1'b1;
                    end
                end
                OP_CLOSE: begin
                    if (r_cnt == '0) begin
                        n_rsp.status = ST_UNMATCHED;
                    end else if (cur_cell == '0) begin
                        n_cnt = cnt_m1;
                    end else begin
                        n_rsp.jump_taken  = 1'b1;
                        n_rsp.jump_target = ADDR_W'(stack_rdata);
                    end
                end
                default: begin
                end
            endcase
        end
        n_rsp.skipping = (n_skip != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
            r_busy      <= 1'b0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr) begin
                if (r_clr_addr == PTR_LAST) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if (acc) begin
                r_busy <= 1'b1;
            end else if (cmt) begin
                r_busy <= 1'b0;
            end
            if (cmt) begin
                r_ptr       <= n_ptr;
                r_cnt       <= n_cnt;
                r_skip      <= n_skip;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req <= i_req;
        end
        if (cmt) begin
            r_rsp <= n_rsp;
        end
    end

    a_no_read_write_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(acc && tape_we))
        else $error("tape written in the cycle of a request read");

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("loop stack count beyond depth");

    a_ptr_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("cell pointer beyond tape");

    a_jump_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.jump_taken) |-> (r_cnt != '0))
        else $error("jump issued with empty loop stack");

    a_skip_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rsp.skipping == (r_skip != '0)))
        else $error("skipping flag out of step with skip depth");

endmodule

// ===== src/bfx_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Instruction executor bench: a table of directed requests, then random programs fetched by jumps.
module testbench;
    import bfx_pkg::*;

    localparam int     TAPE_CELLS   = 32768;
    localparam int     LOOP_DEPTH   = 64;
    localparam int     RANDOM_ITEMS = 1600;
    localparam int     SKIP_DEEP    = 150;
    localparam int     STEP_CAP     = 120;
    localparam int     HOLD_CYCLES  = 400;
    localparam longint CYCLE_LIMIT  = 4000000;

    typedef struct {
        t_bfx_req req;
        int       reps;
        bit       typed;
        t_bfx_rsp rsp;
    } t_dir_row;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_bfx_req i_req;
    logic     o_valid;
    logic     i_ready;
    t_bfx_rsp o_rsp;

    // executor state as predicted
    logic [BYTE_W-1:0] tape_model [TAPE_CELLS];
    logic [14:0]       cell_ptr;
    logic [ADDR_W-1:0] loop_model [LOOP_DEPTH];
    int                stack_depth;
    logic [SKIP_W-1:0] skip_level;

    t_bfx_rsp   awaited_results[$];
    t_bfx_rsp   want_rsp;
    t_dir_row   dir_table[$];
    logic [7:0] program_text[$];

    int     err_count;
    int     accepted_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     rx_hold;
    bit     hold_go;
    longint cycle_count;

    bf_instruction_executor uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_bfx_req mk_req(logic [7:0] op, logic [15:0] addr, logic [7:0] inb,
                                        logic pend);
        t_bfx_req r;
        r.opcode      = op;
        r.address     = addr;
        r.in_byte     = inb;
        r.program_end = pend;
        return r;
    endfunction

    function automatic t_bfx_rsp mk_rsp(logic ov, logic [7:0] ob, logic jt, logic [15:0] tgt,
                                        logic sk, t_status st);
        t_bfx_rsp r;
        r.out_valid   = ov;
        r.out_byte    = ob;
        r.jump_taken  = jt;
        r.jump_target = tgt;
        r.skipping    = sk;
        r.status      = st;
        return r;
    endfunction

    function automatic void add_row(t_bfx_req req, int reps, bit typed, t_bfx_rsp rsp);
        t_dir_row row;
        row.req   = req;
        row.reps  = reps;
        row.typed = typed;
        row.rsp   = rsp;
        dir_table.push_back(row);
    endfunction

    function automatic t_bfx_rsp execute_instruction(t_bfx_req r);
        t_bfx_rsp          rsp;
        logic [BYTE_W-1:0] cur;
        rsp        = '0;
        rsp.status = ST_OK;
        cur        = tape_model[cell_ptr];
        if (r.program_end) begin
            if (stack_depth != 0 || skip_level != '0) rsp.status = ST_UNCLOSED;
            stack_depth = 0;
            skip_level  = '0;
        end else if (skip_level != '0) begin
            if (r.opcode == OP_OPEN) begin
                if (skip_level < SKIP_MAX) skip_level = skip_level + 1'b1;
            end else if (r.opcode == OP_CLOSE) begin
                skip_level = skip_level - 1'b1;
            end
        end else begin
            case (r.opcode)
                OP_INC:   tape_model[cell_ptr] = cur + 1'b1;
                OP_DEC:   tape_model[cell_ptr] = cur - 1'b1;
                OP_RIGHT: cell_ptr = cell_ptr + 1'b1;
                OP_LEFT:  cell_ptr = cell_ptr - 1'b1;
                OP_OUT: begin
                    rsp.out_valid = 1'b1;
                    rsp.out_byte  = cur;
                end
                OP_IN:    tape_model[cell_ptr] = r.in_byte;
                OP_OPEN: begin
                    if (cur == '0) begin
                        skip_level = 16'd1;
                    end else if (stack_depth >= LOOP_DEPTH) begin
                        rsp.status = ST_FULL;
                    end else begin
                        loop_model[stack_depth] = r.address + 16'd1;
                        stack_depth++;
                    end
                end
                OP_CLOSE: begin
                    if (stack_depth == 0) begin
                        rsp.status = ST_UNMATCHED;
                    end else if (cur == '0) begin
                        stack_depth--;
                    end else begin
                        rsp.jump_taken  = 1'b1;
                        rsp.jump_target = loop_model[stack_depth-1];
                    end
                end
                default: ;
            endcase
        end
        rsp.skipping = (skip_level != '0);
        return rsp;
    endfunction

    function automatic logic [7:0] pick_in_byte();
        return ($urandom_range(4) == 0) ? 8'hFF : 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_opcode();
        int w;
        w = $urandom_range(99);
        if (w < 24) return OP_INC;
        if (w < 36) return OP_DEC;
        if (w < 48) return OP_RIGHT;
        if (w < 58) return OP_LEFT;
        if (w < 70) return OP_OUT;
        if (w < 76) return OP_IN;
        if (w < 86) return OP_OPEN;
        if (w < 96) return OP_CLOSE;
        return 8'($urandom_range(255));
    endfunction

    // kinds: deep nesting, broken brackets, pure noise, well-formed
    function automatic void build_program();
        int         kind;
        int         len;
        int         opens;
        logic [7:0] op;
        program_text.delete();
        kind  = $urandom_range(99);
        len   = $urandom_range(40, 4);
        opens = 0;
        if (kind < 4) begin
            program_text.push_back(OP_INC);
            repeat ($urandom_range(70, 60)) program_text.push_back(OP_OPEN);
        end
        for (int k = 0; k < len; k++) begin
            op = (kind >= 18 && kind < 24) ? 8'($urandom_range(255)) : pick_opcode();
            if (kind >= 24 && op == OP_CLOSE && opens == 0) op = OP_INC;
            if (op == OP_OPEN) opens++;
            else if (op == OP_CLOSE && opens > 0) opens--;
            program_text.push_back(op);
        end
        if (kind >= 24) repeat (opens) program_text.push_back(OP_CLOSE);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    task automatic send_request(input t_bfx_req req, input bit typed, input t_bfx_rsp typed_rsp,
                                output t_bfx_rsp predicted);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predicted = execute_instruction(req);
        awaited_results.push_back(typed ? typed_rsp : predicted);
        accepted_count++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_program();
        logic [15:0] base;
        logic [15:0] idx;
        int          steps;
        t_bfx_rsp    got;
        build_program();
        base  = 16'($urandom_range(65535));
        idx   = '0;
        steps = 0;
        while (int'(idx) < program_text.size() && steps < STEP_CAP) begin
            send_request(mk_req(program_text[idx], base + idx, pick_in_byte(), 1'b0),
                         1'b0, '0, got);
            idx = got.jump_taken ? got.jump_target - base : idx + 16'd1;
            steps++;
        end
        if ($urandom_range(9) != 0)
            send_request(mk_req(8'($urandom_range(255)), 16'($urandom_range(65535)),
                                pick_in_byte(), 1'b1), 1'b0, '0, got);
    endtask

    always @(negedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_rsp), '0);
            end else begin
                want_rsp = awaited_results.pop_front();
                if (o_rsp.out_valid !== want_rsp.out_valid)
                    report_mismatch("out_valid", 32'(o_rsp.out_valid),
                                    32'(want_rsp.out_valid));
                if (o_rsp.out_byte !== want_rsp.out_byte)
                    report_mismatch("out_byte", 32'(o_rsp.out_byte), 32'(want_rsp.out_byte));
                if (o_rsp.jump_taken !== want_rsp.jump_taken)
                    report_mismatch("jump_taken", 32'(o_rsp.jump_taken),
                                    32'(want_rsp.jump_taken));
                if (o_rsp.jump_target !== want_rsp.jump_target)
                    report_mismatch("jump_target", 32'(o_rsp.jump_target),
                                    32'(want_rsp.jump_target));
                if (o_rsp.skipping !== want_rsp.skipping)
                    report_mismatch("skipping", 32'(o_rsp.skipping), 32'(want_rsp.skipping));
                if (o_rsp.status !== want_rsp.status)
                    report_mismatch("status", 32'(o_rsp.status), 32'(want_rsp.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL bf_instruction_executor");
            $finish;
        end
    end

    // hold the receiver off while requests keep coming
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        t_bfx_rsp got;
        int       phase;
        int       dir_count;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req          = '0;
        i_ready        = 1'b0;
        hold_go        = 1'b0;
        err_count      = 0;
        accepted_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 36;
        recv_idle_pct  = 70;
        foreach (tape_model[k]) tape_model[k] = '0;
        foreach (loop_model[k]) loop_model[k] = '0;
        cell_ptr    = '0;
        stack_depth = 0;
        skip_level  = '0;

        add_row(mk_req(OP_OUT,   16'h0000, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b1, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_CLOSE, 16'hFFFF, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_UNMATCHED));
        add_row(mk_req(OP_DEC,   16'h0001, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_OUT,   16'h0002, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_INC,   16'h0003, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_LEFT,  16'h0004, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_IN,    16'h0005, 8'hFF, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_OUT,   16'h0006, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b1, 8'hFF, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_RIGHT, 16'h0007, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_IN,    16'h0008, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_OPEN,  16'h1234, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, ST_OK));
        // drive the skip depth deep, then unwind it
        add_row(mk_req(OP_OPEN,  16'h1235, 8'h00, 1'b0), SKIP_DEEP, 1'b0, '0);
        add_row(mk_req(OP_INC,   16'h1236, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, ST_OK));
        add_row(mk_req(OP_CLOSE, 16'h1237, 8'h00, 1'b0), SKIP_DEEP, 1'b0, '0);
        add_row(mk_req(OP_CLOSE, 16'h1238, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_IN,    16'h1239, 8'h01, 1'b0), 1, 1'b0, '0);
        add_row(mk_req(OP_OPEN,  16'hFFFF, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_CLOSE, 16'h0007, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b1, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_DEC,   16'h0008, 8'h00, 1'b0), 1, 1'b0, '0);
        add_row(mk_req(OP_CLOSE, 16'h0009, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(OP_CLOSE, 16'h000A, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_UNMATCHED));
        add_row(mk_req(OP_INC,   16'h000B, 8'h00, 1'b0), 1, 1'b0, '0);
        add_row(mk_req(OP_OPEN,  16'h8000, 8'h00, 1'b0), LOOP_DEPTH, 1'b0, '0);
        add_row(mk_req(OP_OPEN,  16'h8001, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_FULL));
        add_row(mk_req(OP_CLOSE, 16'h8002, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b1, 16'h8001, 1'b0, ST_OK));
        add_row(mk_req(OP_OUT,   16'h8003, 8'h00, 1'b1), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_UNCLOSED));
        add_row(mk_req(OP_DEC,   16'h0000, 8'h00, 1'b0), 1, 1'b0, '0);
        add_row(mk_req(OP_OPEN,  16'h0001, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b1, ST_OK));
        add_row(mk_req(OP_INC,   16'h0002, 8'h00, 1'b1), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_UNCLOSED));
        add_row(mk_req(8'hFF,    16'hFFFF, 8'hFF, 1'b1), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(8'h00,    16'h0000, 8'h00, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));
        add_row(mk_req(8'hFF,    16'h5555, 8'hAA, 1'b0), 1, 1'b1,
                mk_rsp(1'b0, 8'h00, 1'b0, 16'h0000, 1'b0, ST_OK));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[n]) begin
            repeat (dir_table[n].reps)
                send_request(dir_table[n].req, dir_table[n].typed && dir_table[n].reps == 1,
                             dir_table[n].rsp, got);
        end
        dir_count = accepted_count;

        hold_go = 1'b1;
        phase   = 0;
        while (accepted_count - dir_count < RANDOM_ITEMS) begin
            if (phase == 0 && accepted_count - dir_count >= RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 70;
                recv_idle_pct = 36;
                phase = 1;
            end else if (phase == 1 && accepted_count - dir_count >= 2 * RANDOM_ITEMS / 3) begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                phase = 2;
            end
            run_program();
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS bf_instruction_executor");
        end else begin
            $display("FAIL bf_instruction_executor");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bfx_pkg.sv
src/bfx_ram.sv
src/bf_instruction_executor.sv
sim/testbench.sv
